// ===== design/hpa_pkg.sv =====
// Package for the half-precision adder: binary16 field constants and the
// classification struct. No dependencies.
`timescale 1ns / 1ps
package hpa_pkg;
	localparam logic [15:0] NAN_OUT = 16'h7fff;
	localparam logic [14:0] INF_MAG = 15'h7c00;

	typedef struct packed {
		logic nan;
		logic a_inf;
		logic b_inf;
		logic sa;
		logic sb;
	} hpa_class_t;
endpackage

// ===== design/hpa_core.sv =====
// Combinational binary16 add with round to nearest, ties to even.
// Uses hpa_pkg for constants.
`timescale 1ns / 1ps
module hpa_core (
	input  logic [15:0] a,
	input  logic [15:0] b,
	output logic [15:0] sum
);
	hpa_pkg::hpa_class_t cls;
	logic [40:0] ma, mb, m;
	logic        sign;
	logic [5:0]  p;
	logic [5:0]  shift;
	logic [40:0] shifted, rem, halfway, mask;
	logic [10:0] sig;
	logic [15:0] bits;

	// Widen a finite half to a multiple of 2^-24.
	function automatic logic [40:0] mag(input logic [15:0] h);
		logic [40:0] s;
		s = {30'd0, (h[14:10] != 5'd0), h[9:0]};
		if (h[14:10] != 5'd0) begin
			s = s << (h[14:10] - 5'd1);
		end
		return s;
	endfunction

	// Classify the operands.
	always_comb begin
		cls.sa = a[15];
		cls.sb = b[15];
		cls.nan = (a[14:10] == 5'h1f && a[9:0] != 10'd0) ||
			(b[14:10] == 5'h1f && b[9:0] != 10'd0);
		cls.a_inf = a[14:0] == hpa_pkg::INF_MAG;
		cls.b_inf = b[14:0] == hpa_pkg::INF_MAG;
	end

	// Align, add or subtract, normalize and round.
	always_comb begin
		ma = mag(a);
		mb = mag(b);
		if (cls.sa == cls.sb) begin
			m = ma + mb;
			sign = cls.sa;
		end else if (ma >= mb) begin
			m = ma - mb;
			sign = cls.sa;
		end else begin
			m = mb - ma;
			sign = cls.sb;
		end
		p = 6'd0;
		for (int i = 0; i < 41; i++) begin
			if (m[i]) begin
				p = 6'(i);
			end
		end
		shift = (p >= 6'd10) ? p - 6'd10 : 6'd1;
		shifted = m >> shift;
		sig = shifted[10:0];
		mask = (41'd1 << shift) - 41'd1;
		rem = m & mask;
		halfway = 41'd1 << (shift - 6'd1);
		bits = {1'b0, shift[4:0], 10'd0} + {5'd0, sig};
		if (rem > halfway || (rem == halfway && sig[0])) begin
			bits = bits + 16'd1;
		end
		if (bits >= {1'b0, hpa_pkg::INF_MAG}) begin
			bits = {1'b0, hpa_pkg::INF_MAG};
		end

		if (cls.nan) begin
			sum = hpa_pkg::NAN_OUT;
		end else if (cls.a_inf && cls.b_inf) begin
			sum = (cls.sa == cls.sb) ? {cls.sa, hpa_pkg::INF_MAG} : hpa_pkg::NAN_OUT;
		end else if (cls.a_inf) begin
			sum = {cls.sa, hpa_pkg::INF_MAG};
		end else if (cls.b_inf) begin
			sum = {cls.sb, hpa_pkg::INF_MAG};
		end else if (m == 41'd0) begin
			sum = {cls.sa & cls.sb, 15'd0};
		end else if (m < 41'h800) begin
			sum = {sign, m[14:0]};
		end else begin
			sum = {sign, bits[14:0]};
		end
	end
endmodule

// ===== design/half_precision_adder.sv =====
// Top level of the binary16 adder: input register, adder logic, result
// register. Depends on hpa_core and hpa_pkg.
//
//  channel | signals                          | direction
//  in      | in_valid, in_stall, addend_a/b   | upstream -> block
//  out     | out_valid, out_stall, sum_bits   | block -> downstream
//
// One beat per cycle while the output is not stalled; each beat passes the operand register, then the result register.
// The sum is computed combinationally between the two registers.
// Reset clears the valid flags only. A stall on a valid output holds the result
// stage, and holds the operand stage and stalls the input only when both stages are full.
`timescale 1ns / 1ps
module half_precision_adder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] addend_a,
	input  logic [15:0] addend_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] sum_bits
);
	logic [15:0] a_s1, b_s1, sum_c;
	logic        valid_s1, adv_s1;

	// The result stage loads when empty or being taken.
	assign adv_s1   = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;

	// Operand stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			a_s1 <= addend_a;
			b_s1 <= addend_b;
		end
	end

	hpa_core u_core (
		.a   (a_s1),
		.b   (b_s1),
		.sum (sum_c)
	);

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			sum_bits <= sum_c;
		end
	end
endmodule

// ===== tb/hpa_checker.sv =====
// Checker for the binary16 adder: watches both channels, predicts each sum and
// compares it with the output beat. Depends on hpa_pkg.
`timescale 1ns / 1ps
module hpa_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [15:0] addend_a,
	input  logic [15:0] addend_b,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] sum_bits,
	output int          fail_count,
	output int          pending_sums
);
	logic [15:0] sum_queue[$];

	// Magnitude of a finite half as an integer count of 2^-24.
	function automatic logic [63:0] scaled_mag(input logic [15:0] h);
		logic [63:0] sig;
		sig = {54'd0, h[9:0]};
		if (h[14:10] == 5'd0)
			return sig;
		sig[10] = 1'b1;
		return sig << (h[14:10] - 1);
	endfunction

	// Correctly rounded binary16 sum, ties to even.
	function automatic logic [15:0] predict_sum(input logic [15:0] a, input logic [15:0] b);
		logic a_nan, b_nan, a_inf, b_inf, sgn;
		logic [63:0] ma, mb, m, rem, halfway;
		int msb, shift;
		logic [31:0] sig, bits;
		a_nan = (a[14:10] == 5'h1f) && (a[9:0] != 0);
		b_nan = (b[14:10] == 5'h1f) && (b[9:0] != 0);
		a_inf = a[14:0] == hpa_pkg::INF_MAG;
		b_inf = b[14:0] == hpa_pkg::INF_MAG;
		if (a_nan || b_nan)
			return hpa_pkg::NAN_OUT;
		if (a_inf && b_inf)
			return (a[15] == b[15]) ? {a[15], hpa_pkg::INF_MAG} : hpa_pkg::NAN_OUT;
		if (a_inf)
			return {a[15], hpa_pkg::INF_MAG};
		if (b_inf)
			return {b[15], hpa_pkg::INF_MAG};
		ma = scaled_mag(a);
		mb = scaled_mag(b);
		if (a[15] == b[15]) begin
			m = ma + mb;
			sgn = a[15];
		end else if (ma >= mb) begin
			m = ma - mb;
			sgn = a[15];
		end else begin
			m = mb - ma;
			sgn = b[15];
		end
		if (m == 0)
			return {a[15] & b[15], 15'd0};
		if (m < 64'h800)
			return {sgn, m[14:0]};
		msb = 0;
		while (msb < 63 && (m >> (msb + 1)) != 0)
			msb++;
		shift = msb - 10;
		sig = 32'(m >> shift);
		rem = m & ((64'd1 << shift) - 1);
		halfway = 64'd1 << (shift - 1);
		bits = (32'(shift) << 10) + sig;
		if (rem > halfway || (rem == halfway && sig[0]))
			bits = bits + 1;
		if (bits >= 32'h7c00)
			bits = 32'h7c00;
		return {sgn, bits[14:0]};
	endfunction

	assign pending_sums = sum_queue.size();

	// Queue a prediction per input beat; check each output beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
			sum_queue.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (sum_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected output beat: sum_bits=%h", sum_bits);
					fail_count <= fail_count + 1;
				end else begin
					if (sum_queue[0] !== sum_bits) begin
						if (fail_count < 10)
							$display("sum mismatch: expected %h, got %h",
								sum_queue[0], sum_bits);
						fail_count <= fail_count + 1;
					end
					void'(sum_queue.pop_front());
				end
			end
			if (in_valid && !in_stall)
				sum_queue.push_back(predict_sum(addend_a, addend_b));
		end
	end
endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the binary16 adder: clock, reset, operand stimulus and
// verdict. Depends on half_precision_adder, hpa_checker and hpa_pkg.
`timescale 1ns / 1ps
module tb_top;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] addend_a = '0;
	logic [15:0] addend_b = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] sum_bits;
	int          fail_count;
	int          pending_sums;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	always #5 clk = ~clk;

	half_precision_adder uut (.*);
	hpa_checker checker_i (.*);

	// Receiver stalls at random, per phase.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Random operand, biased toward classes that exercise the corner logic.
	function automatic logic [15:0] pick_half();
		logic [15:0] h;
		h = 16'($urandom);
		case ($urandom_range(9))
			0: h[14:10] = 5'h1f;
			1: h[14:10] = 5'h00;
			2: h[14:10] = 5'h1e;
			3: h[9:0] = 10'd0;
			default: ;
		endcase
		return h;
	endfunction

	// Drive one operand beat and hold it until accepted.
	task automatic send_pair(input logic [15:0] a, input logic [15:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		addend_a <= a;
		addend_b <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [15:0] corners[16];
		logic [15:0] a, b;
		int wait_cycles;
		corners = '{16'h0000, 16'h8000, 16'h7c00, 16'hfc00, 16'h7e00, 16'hfd01,
			16'h0001, 16'h8001, 16'h03ff, 16'h0400, 16'h7bff, 16'hfbff,
			16'h3c00, 16'hbc00, 16'h3c01, 16'h1400};
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// Directed corners: zeros, infinities, NaNs, subnormals, overflow, ties.
		for (int i = 0; i < 16; i++)
			send_pair(corners[i], corners[(i * 5 + 3) % 16]);
		send_pair(16'h7c00, 16'hfc00);
		send_pair(16'h7bff, 16'h7bff);
		send_pair(16'h7bff, 16'h4000);
		send_pair(16'h3c00, 16'hbc00);
		send_pair(16'h8000, 16'h8000);
		send_pair(16'h3c00, 16'h1000);
		send_pair(16'h3c01, 16'h1000);
		send_pair(16'h0001, 16'h83ff);
		// Random phases: none, sender idle, receiver stall, both.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 71 : (ph == 3) ? 11 : 0;
			recv_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 11 : 0;
			for (int n = 0; n < 410; n++) begin
				a = pick_half();
				b = pick_half();
				if ($urandom_range(3) == 0)
					b = {~a[15], a[14:0]} ^ 16'($urandom_range(3));
				send_pair(a, b);
			end
		end
		in_valid <= 1'b0;
		recv_stall_pct = 0;
		wait_cycles = 0;
		while (pending_sums != 0 && wait_cycles < 1000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (5) @(negedge clk);
		if (fail_count == 0 && pending_sums == 0)
			$display("[half_precision_adder] OK");
		else
			$display("[half_precision_adder] ERROR");
		$finish;
	end

	// Safety limit on run length.
	initial begin
		#2ms;
		$display("[half_precision_adder] ERROR");
		$finish;
	end
endmodule

// ===== half_precision_adder.f =====
design/hpa_pkg.sv
design/hpa_core.sv
design/half_precision_adder.sv
tb/hpa_checker.sv
tb/tb_top.sv
